@@ rtl/chkh_pkg.sv @@
// shared types, codes and constants for the chained hash table
package chkh_pkg;

  localparam int KEY_W          = 64;
  localparam int VALUE_IO_W     = 32;
  localparam int OPCODE_W       = 2;
  localparam int STATUS_W       = 2;
  localparam int ENTRY_COUNT_W  = 9;
  localparam int BUCKET_COUNT_W = 7;

  localparam logic [BUCKET_COUNT_W-1:0] BUCKET_COUNT_RST = 7'd64;

  localparam int DEF_NUM_BUCKETS = 64;
  localparam int DEF_NODE_COUNT  = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_LINK,
    S_NODE,
    S_RESP
  } state_t;

endpackage

@@ rtl/chkh_in_if.sv @@
// input channel: operation transactions
interface chkh_in_if;
  import chkh_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    key;
  logic [VALUE_IO_W-1:0] value_in;

  modport source (output valid, output opcode, output key, output value_in, input ready);
  modport sink   (input valid, input opcode, input key, input value_in, output ready);
endinterface

@@ rtl/chkh_out_if.sv @@
// result channel: one transaction per operation
interface chkh_out_if;
  import chkh_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [VALUE_IO_W-1:0]    value_out;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  output ready);
endinterface

@@ rtl/chained_int_key_hash_table_top.sv @@
// Chained hash table with 64-bit keys over a bump-allocated node pool. Each
// operation yields one result transaction. An add or a lookup first reduces
// the key modulo the active bucket count in an iterative unit (two key bits
// per cycle over the 64-bit key), then reads the bucket head memory. An add
// then writes the node and head in the same cycle; a lookup reads one node
// per cycle from the node memory's single read port. A clear, an add to a
// full pool and an unused opcode go straight to the response state. One
// operation is in progress at a time; the finished result sits in an output
// register until taken. No clearing pass follows reset.
module chained_int_key_hash_table_top #(
  parameter int NUM_BUCKETS = chkh_pkg::DEF_NUM_BUCKETS,
  parameter int NODE_COUNT  = chkh_pkg::DEF_NODE_COUNT,
  parameter int VALUE_WIDTH = chkh_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [chkh_pkg::BUCKET_COUNT_W-1:0] cfg_wdata,
  chkh_in_if.sink                             in_ch,
  chkh_out_if.source                          out_ch
);
  import chkh_pkg::*;

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int CW  = $clog2(NODE_COUNT + 1);
  localparam int BKW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NBW = $clog2(NUM_BUCKETS + 1);
  localparam int DW  = (NBW > BUCKET_COUNT_W) ? NBW : BUCKET_COUNT_W;

  state_t state_r, state_nxt;

  logic [BUCKET_COUNT_W-1:0] cfg_r;
  op_t                       op_r;
  logic [KEY_W-1:0]          key_r;
  logic [VALUE_WIDTH-1:0]    val_r;
  logic [BKW-1:0]            bucket_r;
  logic [CW-1:0]             held_r;
  logic [NUM_BUCKETS-1:0]    hvld_r;
  logic [NW-1:0]             head_mem [NUM_BUCKETS];
  logic [NW-1:0]             head_rdata_r;
  status_t                   res_status_r;
  logic [VALUE_IO_W-1:0]     res_value_r;
  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [VALUE_IO_W-1:0]     out_value_r;
  logic [ENTRY_COUNT_W-1:0]  out_count_r;

  logic                   accept, full, hv;
  logic                   mod_start, mod_done;
  logic [DW-1:0]          active, mod_rem;
  logic                   res_load, out_load, do_clear, do_add;
  status_t                res_status;
  logic [VALUE_IO_W-1:0]  res_value;
  logic [NW-1:0]          node_raddr;
  logic [KEY_W-1:0]       node_rkey;
  logic [VALUE_WIDTH-1:0] node_rval;
  logic [NW-1:0]          node_rlink;
  logic                   node_rlv;

  assign accept = in_ch.valid && in_ch.ready;
  assign full   = (held_r == CW'(NODE_COUNT));
  assign hv     = hvld_r[bucket_r];

  // active bucket count, clamped to 1..NUM_BUCKETS
  always_comb begin
    if (cfg_r == '0) active = DW'(1);
    else if (DW'(cfg_r) > DW'(NUM_BUCKETS)) active = DW'(NUM_BUCKETS);
    else active = DW'(cfg_r);
  end

  chkh_mod #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_ch.key),
    .divisor  (active),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  chkh_nodes #(.NODE_COUNT(NODE_COUNT), .NW(NW), .VW(VALUE_WIDTH)) u_nodes (
    .clk   (clk),
    .we    (do_add),
    .waddr (NW'(held_r)),
    .wkey  (key_r),
    .wval  (val_r),
    .wlink (head_rdata_r),
    .wlv   (hv),
    .raddr (node_raddr),
    .rkey  (node_rkey),
    .rval  (node_rval),
    .rlink (node_rlink),
    .rlv   (node_rlv)
  );

  // next state and strobes
  always_comb begin
    state_nxt  = state_r;
    mod_start  = 1'b0;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_value  = '0;
    do_clear   = 1'b0;
    do_add     = 1'b0;
    out_load   = 1'b0;
    node_raddr = node_rlink;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_ch.opcode))
            OP_ADD: begin
              if (full) begin
                res_load   = 1'b1;
                res_status = STAT_FULL;
                state_nxt  = S_RESP;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_HASH;
              end
            end
            OP_LOOKUP: begin
              mod_start = 1'b1;
              state_nxt = S_HASH;
            end
            OP_CLEAR: begin
              do_clear  = 1'b1;
              res_load  = 1'b1;
              state_nxt = S_RESP;
            end
            default: begin
              res_load  = 1'b1;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_HASH: begin
        if (mod_done) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        state_nxt = S_LINK;
      end
      S_LINK: begin
        if (op_r == OP_ADD) begin
          do_add    = 1'b1;
          res_load  = 1'b1;
          state_nxt = S_RESP;
        end else if (!hv) begin
          res_load   = 1'b1;
          res_status = STAT_MISS;
          state_nxt  = S_RESP;
        end else begin
          node_raddr = head_rdata_r;
          state_nxt  = S_NODE;
        end
      end
      S_NODE: begin
        if (node_rkey == key_r) begin
          res_load  = 1'b1;
          res_value = VALUE_IO_W'(node_rval);
          state_nxt = S_RESP;
        end else if (!node_rlv) begin
          res_load   = 1'b1;
          res_status = STAT_MISS;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= BUCKET_COUNT_RST;
      held_r      <= '0;
      hvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cfg_r <= cfg_wdata;
      if (do_clear) begin
        held_r <= '0;
        hvld_r <= '0;
      end else if (do_add) begin
        held_r           <= held_r + 1'b1;
        hvld_r[bucket_r] <= 1'b1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_ch.opcode);
      key_r <= in_ch.key;
      val_r <= VALUE_WIDTH'(in_ch.value_in);
    end
    if (mod_done) bucket_r <= BKW'(mod_rem);
    if (res_load) begin
      res_status_r <= res_status;
      res_value_r  <= res_value;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_count_r  <= ENTRY_COUNT_W'(held_r);
    end
  end

  // bucket head memory, registered read
  always_ff @(posedge clk) begin
    if (do_add) head_mem[bucket_r] <= NW'(held_r);
    head_rdata_r <= head_mem[bucket_r];
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.value_out   = out_value_r;
  assign out_ch.entry_count = out_count_r;

endmodule

@@ rtl/chkh_mod.sv @@
// iterative key modulo bucket count, two dividend bits per cycle
module chkh_mod #(
  parameter int DW = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [chkh_pkg::KEY_W-1:0] dividend,
  input  logic [DW-1:0]            divisor,
  output logic                     done,
  output logic [DW-1:0]            rem
);
  import chkh_pkg::*;

  localparam int STEPS = KEY_W / 2;
  localparam int CNTW  = $clog2(STEPS);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [KEY_W-1:0] sh_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   div_r;
  logic [DW:0]     t1, t2;
  logic [DW-1:0]   r1, rem_nxt;

  // two restoring steps on the running remainder
  always_comb begin
    t1 = {rem_r, sh_r[KEY_W-1]};
    if (t1 >= {1'b0, div_r}) t1 = t1 - {1'b0, div_r};
    r1 = t1[DW-1:0];
    t2 = {r1, sh_r[KEY_W-2]};
    if (t2 >= {1'b0, div_r}) t2 = t2 - {1'b0, div_r};
    rem_nxt = t2[DW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNTW'(STEPS - 1)) busy_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= sh_r << 2;
      rem_r <= rem_nxt;
    end
  end

  assign done = busy_r && (cnt_r == CNTW'(STEPS - 1));
  assign rem  = rem_nxt;

endmodule

@@ rtl/chkh_nodes.sv @@
// node pool memory: key, value and chain link per node
module chkh_nodes #(
  parameter int NODE_COUNT = 256,
  parameter int NW         = 8,
  parameter int VW         = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [NW-1:0]              waddr,
  input  logic [chkh_pkg::KEY_W-1:0] wkey,
  input  logic [VW-1:0]              wval,
  input  logic [NW-1:0]              wlink,
  input  logic                       wlv,
  input  logic [NW-1:0]              raddr,
  output logic [chkh_pkg::KEY_W-1:0] rkey,
  output logic [VW-1:0]              rval,
  output logic [NW-1:0]              rlink,
  output logic                       rlv
);
  import chkh_pkg::*;

  localparam int EW = KEY_W + VW + NW + 1;

  logic [EW-1:0] mem [NODE_COUNT];
  logic [EW-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkey, wval, wlink, wlv};
    rdata_r <= mem[raddr];
  end

  assign {rkey, rval, rlink, rlv} = rdata_r;

endmodule
